@@ hw/rtl/abst_pkg.sv @@
// Shared types and constants for the array binary search tree unit.
package abst_pkg;
   localparam int unsigned KeyWidth = 32;
   localparam int unsigned SlotOutWidth = 6;
   localparam int unsigned TallyWidth = 6;
   localparam int unsigned HeightWidth = 4;

   typedef logic signed [KeyWidth-1:0] key_type;

   typedef struct packed {
      logic stored;
      logic [SlotOutWidth-1:0] slot;
      logic [TallyWidth-1:0] leaf_total;
      logic [TallyWidth-1:0] inner_total;
      logic signed [HeightWidth-1:0] tree_height;
   } rsp_type;
endpackage

@@ hw/rtl/abst_if.sv @@
// Valid/ready channel interfaces for requests and responses.
interface abst_req_if import abst_pkg::*; ();
   logic valid;
   logic ready;
   key_type key_value;
   modport source (output valid, output key_value, input ready);
   modport sink (input valid, input key_value, output ready);
endinterface

interface abst_rsp_if import abst_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ hw/rtl/abst_cell.sv @@
// One tree level: holds that level's keys and present bits, steers the walking key.
module abst_cell import abst_pkg::*; #(
   parameter int unsigned LEVEL = 0,
   parameter int unsigned SLOTS = 63,
   parameter int unsigned IDXW = 6
) (
   input  logic clock,
   input  logic reset,
   input  logic in_active,
   input  logic in_done,
   input  logic [IDXW-1:0] in_idx,
   input  key_type in_key,
   output logic out_active,
   output logic out_done,
   output logic [IDXW-1:0] out_idx,
   output key_type out_key,
   output logic out_sib
);
   localparam int unsigned First = (1 << LEVEL) - 1;
   localparam int unsigned Count = (First + (1 << LEVEL) <= SLOTS) ?
                                   (1 << LEVEL) : (SLOTS - First);
   localparam int unsigned LW = (LEVEL == 0) ? 1 : LEVEL;

   key_type store_ff [Count];
   logic [Count-1:0] present_ff;
   logic active_ff, done_ff, sib_ff;
   logic [IDXW-1:0] idx_ff;
   key_type key_ff;

   logic [LW-1:0] loc;
   logic here, sib_here;
   logic [LW-1:0] sib_loc;
   logic [IDXW:0] child;

   always_comb begin
      loc = LW'(in_idx - IDXW'(First));
      sib_loc = loc ^ LW'(1);
      // a slot past the end of a partial last level counts as taken
      here = (32'(loc) >= Count) || present_ff[loc];
      sib_here = (LEVEL != 0) && (32'(sib_loc) < Count) && present_ff[sib_loc];
      child = {1'b0, in_idx} + {1'b0, in_idx} +
              ((store_ff[loc] > in_key) ? (IDXW+1)'(1) : (IDXW+1)'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= '0;
         active_ff <= 1'b0;
      end else begin
         active_ff <= in_active;
         if (in_active && !in_done && !here) begin
            present_ff[loc] <= 1'b1;
         end
      end
      if (in_active && !in_done && !here) store_ff[loc] <= in_key;
      key_ff <= in_key;
      if (in_done) begin
         done_ff <= 1'b1;
         idx_ff <= in_idx;
         sib_ff <= 1'b0;
      end else if (!here) begin
         done_ff <= 1'b1;
         idx_ff <= in_idx;
         sib_ff <= sib_here;
      end else begin
         done_ff <= 1'b0;
         idx_ff <= child[IDXW-1:0];
         sib_ff <= 1'b0;
      end
   end

   assign out_active = active_ff;
   assign out_done = done_ff;
   assign out_idx = idx_ff;
   assign out_key = key_ff;
   assign out_sib = sib_ff;
endmodule

@@ hw/rtl/abst_stats.sv @@
// Running leaf, inner-node and height tallies, updated once per placed key.
module abst_stats import abst_pkg::*; #(
   parameter int unsigned IDXW = 6,
   parameter int unsigned DW = 3
) (
   input  logic clock,
   input  logic reset,
   input  logic upd,
   input  logic placed,
   input  logic [IDXW-1:0] idx,
   input  logic [DW-1:0] depth,
   input  logic sib,
   output rsp_type rsp
);
   logic [IDXW:0] leaf_ff, inner_ff;
   logic [DW-1:0] depth_ff;
   logic empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_ff <= '0; inner_ff <= '0; depth_ff <= '0; empty_ff <= 1'b1;
      end else if (upd && placed) begin
         empty_ff <= 1'b0;
         if (idx == '0) begin
            leaf_ff <= (IDXW+1)'(1); inner_ff <= '0; depth_ff <= '0;
         end else begin
            if (sib) leaf_ff <= leaf_ff + (IDXW+1)'(1);
            else inner_ff <= inner_ff + (IDXW+1)'(1);
            if (depth > depth_ff) depth_ff <= depth;
         end
      end
   end

   function automatic logic [TallyWidth-1:0] sat(input logic [IDXW:0] v);
      sat = (v > (IDXW+1)'(63)) ? TallyWidth'(63) : TallyWidth'(v);
   endfunction

   always_comb begin
      rsp.stored = placed;
      rsp.slot = placed ? SlotOutWidth'(idx) : '0;
      rsp.leaf_total = sat(leaf_ff);
      rsp.inner_total = sat(inner_ff);
      rsp.tree_height = empty_ff ? -4'sd1 :
                        ((DW > 3 && depth_ff > DW'(7)) ? 4'sd7 : HeightWidth'(depth_ff));
   end
endmodule

@@ hw/rtl/array_bst_insert_with_stats_unit.sv @@
// Top level of the array binary search tree insert unit with statistics.
// A key enters a chain of level cells, one per tree level (six at 63 slots);
// each cell holds the keys of its level and passes the walking key and index
// to the next level every cycle. The key is written in the first empty slot
// it meets and the sibling of that slot is checked in the same cell. After the
// last level the statistics register updates and the result is presented.
// A result passes through the level cells, the capture registers and the
// statistics register before it is presented; the next key is taken the cycle
// after the result transfer, so one key is in flight at a time. A key that walks
// past the array is reported with stored = 0 and leaves the statistics unchanged.
module array_bst_insert_with_stats_unit import abst_pkg::*; #(
   parameter int unsigned SLOTS = 63
) (
   input logic clock,
   input logic reset,
   abst_req_if.sink req,
   abst_rsp_if.source rsp
);
   localparam int unsigned Levels = $clog2(SLOTS + 1);
   localparam int unsigned IDXW = $clog2(2 * SLOTS + 3);
   localparam int unsigned DW = (Levels < 2) ? 1 : $clog2(Levels);

   logic act [Levels+1];
   logic dn [Levels+1];
   logic [IDXW-1:0] ix [Levels+1];
   key_type ky [Levels+1];
   logic sb [Levels+1];
   logic [DW-1:0] lvl [Levels+1];

   logic busy_ff, out_ff, upd_ff, sib_ff, dn_ff;
   logic [IDXW-1:0] idx_ff;
   logic [DW-1:0] dep_ff;
   rsp_type stat;

   assign req.ready = !busy_ff && !reset;
   assign act[0] = req.valid && req.ready;
   assign dn[0] = 1'b0;
   assign ix[0] = '0;
   assign ky[0] = req.key_value;
   assign sb[0] = 1'b0;
   assign lvl[0] = '0;

   for (genvar g = 0; g < Levels; g++) begin : g_lvl
      logic sib_raw;
      logic [DW-1:0] lv_ff;
      abst_cell #(.LEVEL(g), .SLOTS(SLOTS), .IDXW(IDXW)) u_cell (
         .clock(clock), .reset(reset),
         .in_active(act[g]), .in_done(dn[g]), .in_idx(ix[g]), .in_key(ky[g]),
         .out_active(act[g+1]), .out_done(dn[g+1]), .out_idx(ix[g+1]),
         .out_key(ky[g+1]), .out_sib(sib_raw));
      // carry the sibling flag and the depth of the first empty slot
      logic sbk_ff;
      always_ff @(posedge clock) begin
         sbk_ff <= dn[g] && sb[g];
         lv_ff <= dn[g] ? lvl[g] : DW'(g);
      end
      assign sb[g+1] = sbk_ff | sib_raw;
      assign lvl[g+1] = lv_ff;
   end

   // walk ended inside the array when done flag is set at the tail
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; out_ff <= 1'b0; upd_ff <= 1'b0;
      end else begin
         upd_ff <= act[Levels];
         if (act[0]) busy_ff <= 1'b1;
         if (upd_ff) out_ff <= 1'b1;
         if (out_ff && rsp.ready) begin
            out_ff <= 1'b0; busy_ff <= 1'b0;
         end
      end
      if (act[Levels]) begin
         dn_ff <= dn[Levels]; idx_ff <= ix[Levels];
         sib_ff <= sb[Levels]; dep_ff <= lvl[Levels];
      end
   end

   abst_stats #(.IDXW(IDXW), .DW(DW)) u_stats (
      .clock(clock), .reset(reset), .upd(upd_ff), .placed(dn_ff),
      .idx(idx_ff), .depth(dep_ff), .sib(sib_ff), .rsp(stat));

   assign rsp.valid = out_ff;
   assign rsp.payload = stat;
endmodule

@@ hw/rtl/abst_checker.sv @@
// Port-level assertions for the tree unit, bound to the top level.
module abst_checker import abst_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_payload
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   a_drop_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.stored |-> rsp_payload.slot == '0)
      else $error("dropped key reports a slot");
   a_height_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.stored |-> rsp_payload.tree_height != -4'sd1)
      else $error("empty height after a store");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");
endmodule

bind array_bst_insert_with_stats_unit abst_checker u_abst_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload));
